>>> sv/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, skipped while reset is asserted.
`define VPFL_ASSERT(lbl, ck, rstn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (prop)) \
		else $error(msg);

// Check that a condition never holds on a rising clock edge.
`define VPFL_NEVER(lbl, ck, rstn, cond, msg) \
	`VPFL_ASSERT(lbl, ck, rstn, !(cond), msg)

`endif

>>> sv/vpfl_pkg.sv
// Shared constants and types of the versioned page free list allocator.
package vpfl_pkg;

	localparam int PAGE_FIELD_W = 32;
	localparam int VER_FIELD_W  = 64;
	localparam int STATUS_W     = 2;

	localparam int FREE_DEPTH_DEF   = 64;
	localparam int PAGE_BITS_DEF    = 32;
	localparam int VERSION_BITS_DEF = 64;

	localparam logic [PAGE_FIELD_W-1:0] MAX_PAGES_RESET = 32'hFFFF_FFFE;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_PAGE = 2'd2;

	// Command broadcast to every cell of the sorted chain.
	typedef struct packed {
		logic ins;
		logic pop;
	} cell_ctl_t;

endpackage

>>> sv/vpfl_if.sv
// Request and response channel interfaces of the page allocator.
interface vpfl_req_if import vpfl_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    op;
	logic [PAGE_FIELD_W-1:0] freed_page;
	logic [VER_FIELD_W-1:0]  obsolete_version;
	logic [VER_FIELD_W-1:0]  commit_version;

	modport source (output valid, op, freed_page, obsolete_version, commit_version,
		input ready);
	modport sink (input valid, op, freed_page, obsolete_version, commit_version,
		output ready);
endinterface

interface vpfl_rsp_if import vpfl_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [PAGE_FIELD_W-1:0] page_number;
	logic                    reused;
	logic [STATUS_W-1:0]     status;

	modport source (output valid, page_number, reused, status, input ready);
	modport sink (input valid, page_number, reused, status, output ready);
endinterface

>>> sv/vpfl_cell.sv
// One cell of the version-sorted free page chain.
module vpfl_cell import vpfl_pkg::*; #(
	parameter int PAGE_BITS    = PAGE_BITS_DEF,
	parameter int VERSION_BITS = VERSION_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cell_ctl_t               ctl,
	input  logic [VERSION_BITS-1:0] key_ver,
	input  logic [PAGE_BITS-1:0]    new_page,
	input  logic                    left_valid,
	input  logic                    left_keep,
	input  logic [VERSION_BITS-1:0] left_ver,
	input  logic [PAGE_BITS-1:0]    left_page,
	input  logic                    right_valid,
	input  logic [VERSION_BITS-1:0] right_ver,
	input  logic [PAGE_BITS-1:0]    right_page,
	output logic                    valid,
	output logic                    keep,
	output logic [VERSION_BITS-1:0] ver,
	output logic [PAGE_BITS-1:0]    page
);

	logic                    valid_q;
	logic [VERSION_BITS-1:0] ver_q;
	logic [PAGE_BITS-1:0]    page_q;

	// Entry stays in place on insert when it is not newer than the key.
	assign keep  = valid_q && (ver_q <= key_ver);
	assign valid = valid_q;
	assign ver   = ver_q;
	assign page  = page_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.pop) begin
			valid_q <= right_valid;
		end else if (ctl.ins && !keep) begin
			valid_q <= left_keep ? 1'b1 : left_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			ver_q  <= right_ver;
			page_q <= right_page;
		end else if (ctl.ins && !keep) begin
			if (left_keep) begin
				ver_q  <= key_ver;
				page_q <= new_page;
			end else begin
				ver_q  <= left_ver;
				page_q <= left_page;
			end
		end
	end

endmodule

>>> sv/versioned_page_free_list_allocator.sv
// Top level of the versioned page allocator with a version-sorted free page chain.
//
//  channel | dir | handshake       | payload
//  --------+-----+-----------------+---------------------------------------------------
//  req     | in  | valid / ready   | op, freed_page, obsolete_version, commit_version
//  rsp     | out | valid / ready   | page_number, reused, status
//  cfg     | in  | cfg_we          | cfg_wdata (max_pages)
//
//  One transaction per cycle; its result shows on rsp the cycle after acceptance.
//  The chain compares every cell against the key in parallel and shifts all cells together,
//  so the head compare, the cell compares and the page counter set the cycle time.
//  req.ready drops only while a result waits in the output register and rsp stalls.
//  Reset empties the chain, sets the page counter to one and max_pages to its default.
module versioned_page_free_list_allocator import vpfl_pkg::*; #(
	parameter int FREE_DEPTH   = FREE_DEPTH_DEF,
	parameter int PAGE_BITS    = PAGE_BITS_DEF,
	parameter int VERSION_BITS = VERSION_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [PAGE_FIELD_W-1:0] cfg_wdata,
	vpfl_req_if.sink                req,
	vpfl_rsp_if.source              rsp
);

	localparam logic [PAGE_BITS-1:0] PAGE_NONE = {PAGE_BITS{1'b1}};

	// Configuration and allocation state
	logic [PAGE_FIELD_W-1:0] max_pages_q;
	logic [PAGE_BITS-1:0]    page_ctr_q;

	// Output register
	logic                    out_valid_q;
	logic [PAGE_BITS-1:0]    page_q;
	logic                    reused_q;
	logic [STATUS_W-1:0]     status_q;

	// Chain taps, one per cell
	logic                    cell_valid [FREE_DEPTH];
	logic                    cell_keep  [FREE_DEPTH];
	logic [VERSION_BITS-1:0] cell_ver   [FREE_DEPTH];
	logic [PAGE_BITS-1:0]    cell_page  [FREE_DEPTH];

	logic                    accept;
	logic                    is_free;
	logic [VERSION_BITS-1:0] key_ver;
	logic [PAGE_BITS-1:0]    new_page;
	logic                    full;
	logic                    head_hit;
	logic [PAGE_FIELD_W-1:0] limit;
	logic                    fresh_ok;
	cell_ctl_t               ctl;

	assign accept   = req.valid && req.ready;
	assign is_free  = (req.op == OP_FREE);
	assign new_page = req.freed_page[PAGE_BITS-1:0];

	// One key serves both operations: the obsolete version for a free,
	// the commit version for an allocate (then cell 0's keep is the head hit).
	assign key_ver = is_free ? req.obsolete_version[VERSION_BITS-1:0]
	                         : req.commit_version[VERSION_BITS-1:0];

	assign full     = cell_valid[FREE_DEPTH-1];
	assign head_hit = cell_keep[0];

	// Clamp the limit so the none marker is never handed out as a fresh page.
	assign limit    = (max_pages_q < PAGE_FIELD_W'(PAGE_NONE)) ? max_pages_q
	                                                           : PAGE_FIELD_W'(PAGE_NONE);
	assign fresh_ok = PAGE_FIELD_W'(page_ctr_q) < limit;

	// Drop frees into a full chain; pop the head only on an allocate hit.
	assign ctl.ins = accept && is_free && !full;
	assign ctl.pop = accept && !is_free && head_hit;

	for (genvar i = 0; i < FREE_DEPTH; i++) begin : g_cell
		logic                    l_valid;
		logic                    l_keep;
		logic [VERSION_BITS-1:0] l_ver;
		logic [PAGE_BITS-1:0]    l_page;
		logic                    r_valid;
		logic [VERSION_BITS-1:0] r_ver;
		logic [PAGE_BITS-1:0]    r_page;

		if (i == 0) begin : g_head
			// Head cell always sees a kept neighbor: an insert lands here at the latest.
			assign l_valid = 1'b0;
			assign l_keep  = 1'b1;
			assign l_ver   = cell_ver[i];
			assign l_page  = cell_page[i];
		end else begin : g_body
			assign l_valid = cell_valid[i-1];
			assign l_keep  = cell_keep[i-1];
			assign l_ver   = cell_ver[i-1];
			assign l_page  = cell_page[i-1];
		end

		if (i == FREE_DEPTH - 1) begin : g_tail
			assign r_valid = 1'b0;
			assign r_ver   = cell_ver[i];
			assign r_page  = cell_page[i];
		end else begin : g_inner
			assign r_valid = cell_valid[i+1];
			assign r_ver   = cell_ver[i+1];
			assign r_page  = cell_page[i+1];
		end

		vpfl_cell #(
			.PAGE_BITS    (PAGE_BITS),
			.VERSION_BITS (VERSION_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.key_ver     (key_ver),
			.new_page    (new_page),
			.left_valid  (l_valid),
			.left_keep   (l_keep),
			.left_ver    (l_ver),
			.left_page   (l_page),
			.right_valid (r_valid),
			.right_ver   (r_ver),
			.right_page  (r_page),
			.valid       (cell_valid[i]),
			.keep        (cell_keep[i]),
			.ver         (cell_ver[i]),
			.page        (cell_page[i])
		);
	end

	// Configuration register and page counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pages_q <= MAX_PAGES_RESET;
			page_ctr_q  <= PAGE_BITS'(1);
		end else begin
			if (cfg_we) begin
				max_pages_q <= cfg_wdata;
			end
			// Advance only on a fresh allocation; hold when out of pages.
			if (accept && !is_free && !head_hit && fresh_ok) begin
				page_ctr_q <= page_ctr_q + PAGE_BITS'(1);
			end
		end
	end

	// Output valid: set on every accepted transaction, clear once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			if (is_free) begin
				page_q   <= PAGE_NONE;
				reused_q <= 1'b0;
				status_q <= full ? ST_FULL : ST_OK;
			end else if (head_hit) begin
				page_q   <= cell_page[0];
				reused_q <= 1'b1;
				status_q <= ST_OK;
			end else if (fresh_ok) begin
				page_q   <= page_ctr_q;
				reused_q <= 1'b0;
				status_q <= ST_OK;
			end else begin
				page_q   <= PAGE_NONE;
				reused_q <= 1'b0;
				status_q <= ST_NO_PAGE;
			end
		end
	end

	assign req.ready       = !out_valid_q || rsp.ready;
	assign rsp.valid       = out_valid_q;
	assign rsp.page_number = PAGE_FIELD_W'(page_q);
	assign rsp.reused      = reused_q;
	assign rsp.status      = status_q;

endmodule

>>> sv/vpfl_checker.sv
// Port-level assertion checker for the page allocator, with its bind.
`include "assert_macros.svh"

module vpfl_checker import vpfl_pkg::*; #(
	parameter int PAGE_BITS = PAGE_BITS_DEF
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [PAGE_FIELD_W-1:0] page_number,
	input logic                    reused,
	input logic [STATUS_W-1:0]     status
);

	localparam logic [PAGE_FIELD_W-1:0] NONE_MARK = PAGE_FIELD_W'({PAGE_BITS{1'b1}});

	`VPFL_ASSERT(a_rsp_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(page_number) && $stable(reused) && $stable(status), "stalled result changed")
	`VPFL_NEVER(a_reuse_ok, clk, arst_n, out_valid && reused && status != ST_OK, "reused page with error status")
	`VPFL_NEVER(a_err_none, clk, arst_n, out_valid && status != ST_OK && page_number != NONE_MARK, "error result carries a page")
	`VPFL_NEVER(a_no_page0, clk, arst_n, out_valid && !reused && status == ST_OK && page_number == '0, "fresh page zero handed out")
	`VPFL_NEVER(a_no_overrun, clk, arst_n, in_valid && in_ready && out_valid && !out_ready, "request taken while result stalled")

endmodule

bind versioned_page_free_list_allocator vpfl_checker #(
	.PAGE_BITS (PAGE_BITS)
) u_vpfl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (req.valid),
	.in_ready    (req.ready),
	.out_valid   (rsp.valid),
	.out_ready   (rsp.ready),
	.page_number (rsp.page_number),
	.reused      (rsp.reused),
	.status      (rsp.status)
);
